// File: design/bmt_pkg.sv
// Package with the shared constants, codes and control types of the bucketed table.
package bmt_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int BUCKET_DEPTH = 16;

    localparam int IDX_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOT_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CNT_W    = 5;
    localparam int ENTRY_AW = IDX_W + SLOT_W;
    localparam int ENTRY_DEPTH = NUM_BUCKETS << SLOT_W;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int TS_W  = 9;
    localparam logic [TS_W-1:0] TS_RESET = 9'd256;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Kinds of single-result outcomes.
    typedef enum logic [1:0] {
        RES_RANGE = 2'd0,
        RES_FULL  = 2'd1,
        RES_ADD   = 2'd2,
        RES_EMPTY = 2'd3
    } t_res_kind;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOK   = 2'd1,
        S_STREAM = 2'd2
    } t_state;

    typedef struct packed {
        logic      capture;
        logic      single;
        t_res_kind kind;
        logic      q_start;
        logic      q_step;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic is_add;
        logic full;
        logic empty;
        logic out_free;
        logic q_last;
    } t_dp_status;

endpackage

// File: design/bmt_if.sv
// Handshake interfaces for the input item channel and the result channel.
interface bmt_in_if import bmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] bucket_index;
    logic [VAL_W-1:0] hold_value;

    modport source (output valid, output opcode, output bucket_index, output hold_value,
                    input ready);
    modport sink   (input valid, input opcode, input bucket_index, input hold_value,
                    output ready);
endinterface

interface bmt_out_if import bmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [VAL_W-1:0] entry_value;
    logic             entry_valid;
    logic             last;

    modport source (output valid, output status, output entry_count, output entry_value,
                    output entry_valid, output last, input ready);
    modport sink   (input valid, input status, input entry_count, input entry_value,
                    input entry_valid, input last, output ready);
endinterface

// File: design/bmt_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
module bmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bmt_ctrl.sv
// Controller state machine that sequences lookup, update and query streaming.
module bmt_ctrl import bmt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_stat,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.single  = 1'b0;
        o_cmd.kind    = RES_RANGE;
        o_cmd.q_start = 1'b0;
        o_cmd.q_step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                // The bucket count is now out of its RAM.
                if (i_stat.in_range && !i_stat.is_add && !i_stat.empty) begin
                    o_cmd.q_start = 1'b1;
                    n_state       = S_STREAM;
                end else if (i_stat.out_free) begin
                    o_cmd.single = 1'b1;
                    n_state      = S_IDLE;
                    if (!i_stat.in_range) begin
                        o_cmd.kind = RES_RANGE;
                    end else if (!i_stat.is_add) begin
                        o_cmd.kind = RES_EMPTY;
                    end else if (i_stat.full) begin
                        o_cmd.kind = RES_FULL;
                    end else begin
                        o_cmd.kind = RES_ADD;
                    end
                end
            end
            S_STREAM: begin
                if (i_stat.out_free) begin
                    o_cmd.q_step = 1'b1;
                    if (i_stat.q_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/bmt_dp.sv
// Datapath: table size, count and entry memories, and the result register.
module bmt_dp import bmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TS_W-1:0]  i_cfg_wdata,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_bucket_index,
    input  logic [VAL_W-1:0] i_hold_value,
    input  logic             i_out_ready,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_stat,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_entry_count,
    output logic [VAL_W-1:0] o_entry_value,
    output logic             o_entry_valid,
    output logic             o_last
);

    logic [TS_W-1:0]   r_table_size;
    logic              r_fill_vld [NUM_BUCKETS];
    logic              r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_val;
    logic              r_in_range;
    logic [CNT_W-1:0]  r_qfill;
    logic [SLOT_W-1:0] r_slot;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_count;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_evalid;
    logic              r_out_last;

    logic [CNT_W-1:0]  fill_rdata;
    logic [CNT_W-1:0]  fill_eff;
    logic [CNT_W-1:0]  fill_inc;
    logic [VAL_W-1:0]  entry_rdata;
    logic              add_wr;
    logic              entry_re;
    logic [SLOT_W-1:0] rd_slot;
    logic              in_range;
    logic              out_free;
    logic              q_last;

    assign in_range = (i_bucket_index < KEY_W'(NUM_BUCKETS)) &&
                      (i_bucket_index < KEY_W'(r_table_size));

    assign fill_eff = r_fill_vld[r_idx] ? fill_rdata : '0;
    assign fill_inc = fill_eff + CNT_W'(1);
    assign add_wr   = i_cmd.single && (i_cmd.kind == RES_ADD);
    assign out_free = !r_out_valid || i_out_ready;
    assign q_last   = (CNT_W'(r_slot) + CNT_W'(1)) == r_qfill;
    assign entry_re = i_cmd.q_start || (i_cmd.q_step && !q_last);
    assign rd_slot  = i_cmd.q_start ? '0 : r_slot + SLOT_W'(1);

    assign o_stat.in_range = r_in_range;
    assign o_stat.is_add   = (r_op == OP_ADD);
    assign o_stat.full     = fill_eff >= CNT_W'(BUCKET_DEPTH);
    assign o_stat.empty    = (fill_eff == '0);
    assign o_stat.out_free = out_free;
    assign o_stat.q_last   = q_last;

    bmt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (add_wr),
        .i_waddr (r_idx),
        .i_wdata (fill_inc),
        .i_re    (i_cmd.capture),
        .i_raddr (i_bucket_index[IDX_W-1:0]),
        .o_rdata (fill_rdata)
    );

    bmt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (add_wr),
        .i_waddr ({r_idx, fill_eff[SLOT_W-1:0]}),
        .i_wdata (r_val),
        .i_re    (entry_re),
        .i_raddr ({r_idx, rd_slot}),
        .o_rdata (entry_rdata)
    );

    // Control state: table size, per-bucket valid bits, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_RESET;
            r_out_valid  <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_fill_vld[b] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    r_fill_vld[b] <= 1'b0;
                end
            end else if (add_wr) begin
                r_fill_vld[r_idx] <= 1'b1;
            end
            if (i_cmd.single || i_cmd.q_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_idx      <= i_bucket_index[IDX_W-1:0];
            r_val      <= i_hold_value;
            r_in_range <= in_range;
        end
        if (i_cmd.q_start) begin
            r_qfill <= fill_eff;
            r_slot  <= '0;
        end else if (i_cmd.q_step && !q_last) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
        if (i_cmd.single) begin
            r_out_value  <= '0;
            r_out_evalid <= 1'b0;
            r_out_last   <= 1'b1;
            case (i_cmd.kind)
                RES_RANGE: begin
                    r_out_status <= ST_RANGE;
                    r_out_count  <= '0;
                end
                RES_FULL: begin
                    r_out_status <= ST_FULL;
                    r_out_count  <= CNT_W'(BUCKET_DEPTH);
                end
                RES_ADD: begin
                    r_out_status <= ST_OK;
                    r_out_count  <= fill_inc;
                end
                default: begin
                    r_out_status <= ST_OK;
                    r_out_count  <= '0;
                end
            endcase
        end else if (i_cmd.q_step) begin
            r_out_status <= ST_OK;
            r_out_count  <= r_qfill;
            r_out_value  <= entry_rdata;
            r_out_evalid <= 1'b1;
            r_out_last   <= q_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_entry_value = r_out_value;
    assign o_entry_valid = r_out_evalid;
    assign o_last        = r_out_last;

endmodule

// File: design/bucketed_multivalue_table.sv
// Top level of the bucketed multivalue table: controller, datapath and checks.
//
//  Channel   Direction  Payload                                          Handshake
//  i_item    in         opcode, bucket_index, hold_value                 valid/ready
//  o_res     out        status, entry_count, entry_value, entry_valid,   valid/ready
//                       last
//  i_cfg_*   in         table_size (9 bits)                              write enable
//
// An add or a single-result item passes the transfer in S_IDLE, whose edge starts the
// registered read of the bucket count RAM, then S_LOOK, which decides and writes back
// and loads the result as it leaves.
// A query of a bucket holding N values streams one value per cycle out of the entry RAM
// read port, more slowly only when the result side stalls.
// Reset clears the control state at once; per-bucket valid bits stand in for the count
// RAM contents, so there is no clearing pass. A table size write clears them as well.
// The result register lets a new item be taken while the last result waits for transfer;
// output stalls hold the stream in place with the entry RAM read port paused.
module bucketed_multivalue_table import bmt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [TS_W-1:0] i_cfg_wdata,
    bmt_in_if.sink          i_item,
    bmt_out_if.source       o_res
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;

    // The controller owns input ready and the sequencing of each item.
    bmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_item.ready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the memories and drives the result register.
    bmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_item.opcode),
        .i_bucket_index (i_item.bucket_index),
        .i_hold_value   (i_item.hold_value),
        .i_out_ready    (o_res.ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_res.valid),
        .o_status       (o_res.status),
        .o_entry_count  (o_res.entry_count),
        .o_entry_value  (o_res.entry_value),
        .o_entry_valid  (o_res.entry_valid),
        .o_last         (o_res.last)
    );

`ifndef SYNTHESIS
    // After an input transfer the block is busy looking up the bucket.
    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken again right after a transfer");

    // A stored value is only ever sent with an ok status and a nonzero count.
    a_entry_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.entry_valid) |->
            (o_res.status == ST_OK && o_res.entry_count != '0))
        else $error("stored value sent with bad status or zero count");

    // A result without a stored value is always the last of its item.
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.entry_valid) |-> o_res.last)
        else $error("single result not marked last");

    // The result register is only loaded when it is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.single || w_cmd.q_step) |-> (!o_res.valid || o_res.ready))
        else $error("pending result overwritten");
`endif

endmodule

// File: dv/bmt_tb_pkg.sv
// Scoreboard class that predicts and checks the results of the bucketed multivalue table.
`timescale 1ns / 100ps
package bmt_tb_pkg;
    import bmt_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] entry_count;
        logic [VAL_W-1:0] entry_value;
        logic             entry_valid;
        logic             last;
    } t_table_result;

    class multimap_scoreboard;
        logic [TS_W-1:0]  table_size;
        logic [CNT_W-1:0] bucket_count [NUM_BUCKETS];
        logic [VAL_W-1:0] bucket_slots [NUM_BUCKETS][BUCKET_DEPTH];
        t_table_result    due_results [$];
        int unsigned      errors;

        function new();
            errors = 0;
            write_table_size(TS_RESET);
        endfunction

        // A size write empties every bucket, just as reset does.
        function void write_table_size(logic [TS_W-1:0] value);
            table_size = value;
            foreach (bucket_count[b]) bucket_count[b] = '0;
        endfunction

        function void push_result(t_status status, int count, logic [VAL_W-1:0] value,
                                  logic entry_valid, logic last);
            t_table_result r;
            r.status      = status;
            r.entry_count = count[CNT_W-1:0];
            r.entry_value = value;
            r.entry_valid = entry_valid;
            r.last        = last;
            due_results.push_back(r);
        endfunction

        // Works out the results of one accepted item and updates the table copy.
        function void note_item(t_opcode op, logic [KEY_W-1:0] idx, logic [VAL_W-1:0] value);
            logic [KEY_W-1:0] in_use;
            int b;
            int n;
            in_use = (table_size > NUM_BUCKETS) ? NUM_BUCKETS : table_size;
            if (idx >= in_use) begin
                push_result(ST_RANGE, 0, '0, 1'b0, 1'b1);
                return;
            end
            b = int'(idx);
            n = int'(bucket_count[b]);
            if (op == OP_ADD) begin
                if (n >= BUCKET_DEPTH) begin
                    push_result(ST_FULL, BUCKET_DEPTH, '0, 1'b0, 1'b1);
                end else begin
                    bucket_slots[b][n] = value;
                    bucket_count[b] = CNT_W'(n + 1);
                    push_result(ST_OK, n + 1, '0, 1'b0, 1'b1);
                end
            end else if (n == 0) begin
                push_result(ST_OK, 0, '0, 1'b0, 1'b1);
            end else begin
                for (int k = 0; k < n; k++)
                    push_result(ST_OK, n, bucket_slots[b][k], 1'b1, k == n - 1);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                         $time, got.status, got.entry_count);
                $display("    value %h valid %b last %b",
                         got.entry_value, got.entry_valid, got.last);
                return;
            end
            want = due_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("entry_value", want.entry_value, got.entry_value);
            check_field("entry_valid", want.entry_valid, got.entry_valid);
            check_field("last", want.last, got.last);
        endfunction
    endclass

endpackage

// File: dv/tb.sv
// Top-level testbench for the bucketed multivalue table: stimulus, result sink and watchdog.
`timescale 1ns / 100ps
module tb;
    import bmt_pkg::*;
    import bmt_tb_pkg::*;

    // Cycles to let pass after the last expected result before the table is touched
    // again. A query gives a result for every stored value, and every item gives at least
    // one result, so the block is idle once the last expected result is in.
    localparam int SETTLE_CYCLES = 4;
    // Cycles without any transfer on either channel before the run is declared hung.
    // The quiet stretches come from receiver hold-offs, sender gaps and the work of the
    // block itself, so this leaves a wide margin.
    localparam int HANG_LIMIT = 1000;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [TS_W-1:0] cfg_wdata;

    bmt_in_if  item_ch ();
    bmt_out_if res_ch ();

    bucketed_multivalue_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_res       (res_ch)
    );

    multimap_scoreboard sb;
    t_table_result      rx_result;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 stall_mode = 0;
    int                 quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one item and returns at the edge where it transfers. The sender works
    // in bursts: when a burst runs out, valid drops and waits out a random gap, so valid
    // never gets a low and a high in the same time step. Long bursts give stretches
    // with no idling at all.
    task automatic send_item(t_opcode op, logic [KEY_W-1:0] idx, logic [VAL_W-1:0] value);
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.bucket_index <= idx;
        item_ch.hold_value   <= value;
        do @(posedge clk); while (!(item_ch.valid === 1'b1 && item_ch.ready === 1'b1));
        sb.note_item(op, idx, value);
    endtask

    // Holds the sender off until every expected result has been seen, then lets
    // the block settle. Table size writes happen only after this.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Two in five indices land in two hot buckets so that they fill up; the rest cover the
    // whole table, the top bucket, the first indices past the end and the full
    // 32-bit range.
    function automatic logic [KEY_W-1:0] pick_index(logic [KEY_W-1:0] in_use,
                                                    logic [KEY_W-1:0] hot_a,
                                                    logic [KEY_W-1:0] hot_b);
        int roll;
        roll = $urandom_range(0, 99);
        if (in_use == 0 || roll < 10) return $urandom;
        if (roll < 16) return in_use + $urandom_range(0, 3);
        if (roll < 22) return in_use - 1;
        if (roll < 62) return roll[0] ? hot_a : hot_b;
        return $urandom_range(0, in_use - 1);
    endfunction

    // One phase: write the table size while idle, then random items. Each phase
    // with buckets in use fills one hot bucket past its depth and reads it back, and
    // each phase pauses once until all results are in.
    task automatic run_phase(logic [TS_W-1:0] size, int n_items);
        logic [KEY_W-1:0] in_use;
        logic [KEY_W-1:0] hot_a;
        logic [KEY_W-1:0] hot_b;
        int               fill_at;
        int               pause_at;
        drain_results();
        cfg_wdata <= size;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_table_size(size);
        in_use   = (size > NUM_BUCKETS) ? NUM_BUCKETS : size;
        hot_a    = (in_use == 0) ? '0 : $urandom_range(0, in_use - 1);
        hot_b    = (in_use == 0) ? '0 : $urandom_range(0, in_use - 1);
        fill_at  = $urandom_range(0, n_items - 1);
        pause_at = $urandom_range(0, n_items - 1);
        for (int k = 0; k < n_items; k++) begin
            if (k == pause_at)
                drain_results();
            if (k == fill_at && in_use != 0) begin
                for (int j = 0; j <= BUCKET_DEPTH; j++)
                    send_item(OP_ADD, hot_a, $urandom);
                send_item(OP_QUERY, hot_a, $urandom);
            end
            send_item(($urandom_range(0, 99) < 60) ? OP_ADD : OP_QUERY,
                      pick_index(in_use, hot_a, hot_b), $urandom);
        end
    endtask

    // Result sink. A result transfers at an edge where valid and ready are both
    // high; it is checked against the oldest expectation. Ready follows a pattern
    // of modes, each held for a while: always ready, coin flip, mostly stalled and
    // a full hold-off.
    always @(posedge clk) begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            rx_result.status      = t_status'(res_ch.status);
            rx_result.entry_count = res_ch.entry_count;
            rx_result.entry_value = res_ch.entry_value;
            rx_result.entry_valid = res_ch.entry_valid;
            rx_result.last        = res_ch.last;
            sb.check_result(rx_result);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                res_ch.ready <= 1'b1;
            end
            1: begin
                res_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                res_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                res_ch.ready <= 1'b0;
            end
        endcase
    end

    // Watchdog: ends the run when neither channel has had a transfer for too long.
    always @(posedge clk) begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = OP_ADD;
        item_ch.bucket_index = '0;
        item_ch.hold_value   = '0;
        res_ch.ready         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset table size: empty query, adds at both ends of
        // the table with extreme values, read-back, out-of-range indices for both
        // opcodes, then one bucket filled to its depth, overfilled and read.
        send_item(OP_QUERY, 32'd0, 32'h0000_0000);
        send_item(OP_ADD, 32'd0, 32'h0000_0000);
        send_item(OP_ADD, 32'd255, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'd255, 32'h0000_0000);
        send_item(OP_ADD, 32'd256, 32'hA5A5_5A5A);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int k = 0; k < BUCKET_DEPTH; k++)
            send_item(OP_ADD, 32'd7, $urandom);
        send_item(OP_ADD, 32'd7, 32'hDEAD_BEEF);
        send_item(OP_QUERY, 32'd7, 32'h0000_0000);

        // Random phases over the table sizes: a single bucket, none at all, the
        // largest value that saturates, random sizes below and above the bucket
        // count, and the full table.
        run_phase(9'd1, 30);
        run_phase(9'd0, 8);
        run_phase(9'd511, 30);
        run_phase(TS_W'($urandom_range(2, 255)), 30);
        run_phase(TS_W'($urandom_range(257, 510)), 30);
        run_phase(TS_RESET, 30);
        drain_results();

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/bmt_pkg.sv
design/bmt_if.sv
design/bmt_ram.sv
design/bmt_ctrl.sv
design/bmt_dp.sv
design/bucketed_multivalue_table.sv
dv/bmt_tb_pkg.sv
dv/tb.sv
